// File: rtl/core/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers shared by the scan point decoder RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define LSPD_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("lspd assertion failed");
`define LSPD_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("lspd assertion failed");
`else
`define LSPD_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define LSPD_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif
`endif

// File: rtl/core/lspd_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Scan point decoder package
// Types, constants and the CORDIC step angle table.
// ---------------------------------------------------------------------------
package lspd_pkg;

  localparam logic [7:0] HDR_BYTE   = 8'hA5;
  localparam int         SKIP_BYTES = 6;
  localparam logic [4:0] MIN_INTEN  = 5'd8;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SLOPE_NEAR  = 3'd0,
    REG_OFFSET_NEAR = 3'd1,
    REG_SLOPE_FAR   = 3'd2,
    REG_OFFSET_FAR  = 3'd3,
    REG_INDEX_BIAS  = 3'd4
  } reg_idx_t;

  localparam int CW        = 36;
  localparam int ZW        = 22;
  localparam int STEPS     = 20;
  localparam int KW        = 5;
  localparam int DVD_W     = 64;
  localparam int DVS_W     = 36;

  localparam int Q_ONE       = 65536;
  localparam int CORDIC_X0   = 39796;
  localparam int SCALE_1E5   = 100000;
  localparam int ANG_MUL     = 9765625;
  localparam int ANG_MUL_W   = 24;
  localparam int ANG_DIV     = 111701072;
  localparam int ANG_MAX     = 9000;
  localparam logic [30:0] RATIO_MAX = 31'h7FFF_FFFF;

  // angle scaling by reciprocal: estimate, then one compare and correct
  localparam int     ANG_SH    = 24;
  localparam int     ANG_XW    = 17;
  localparam int     ANG_QW    = 14;
  localparam int     ANG_RCP_W = 21;
  localparam longint ANG_RCP   = (longint'(ANG_MUL) << ANG_SH) / ANG_DIV;

  function automatic logic signed [ZW-1:0] step_angle(input logic [KW-1:0] k);
    logic signed [ZW-1:0] a;
    case (k)
      5'd0:    a = 22'sd51472;
      5'd1:    a = 22'sd30385;
      5'd2:    a = 22'sd16055;
      5'd3:    a = 22'sd8150;
      5'd4:    a = 22'sd4091;
      5'd5:    a = 22'sd2047;
      5'd6:    a = 22'sd1024;
      5'd7:    a = 22'sd512;
      5'd8:    a = 22'sd256;
      5'd9:    a = 22'sd128;
      5'd10:   a = 22'sd64;
      5'd11:   a = 22'sd32;
      5'd12:   a = 22'sd16;
      5'd13:   a = 22'sd8;
      5'd14:   a = 22'sd4;
      5'd15:   a = 22'sd2;
      5'd16:   a = 22'sd1;
      default: a = '0;
    endcase
    return a;
  endfunction

  typedef enum logic [3:0] {
    OP_NONE, OP_HOLD, OP_CAPTURE, OP_CALC, OP_DIV_P, OP_ATN_P, OP_DIV_Q, OP_ATN_Q,
    OP_SUM, OP_COS_A, OP_COS_Q, OP_MUL_A, OP_MUL_B, OP_DIV_DST, OP_DIV_ANG, OP_EMIT
  } op_t;

  typedef struct packed {
    op_t        op;
    logic       start;
    logic [7:0] idx;
    logic [7:0] kept;
  } lspd_cmd_t;

  typedef struct packed {
    logic hdr_hit;
    logic pt_ok;
    logic div_done;
    logic cor_done;
  } lspd_sts_t;

endpackage

// File: rtl/core/lspd_if.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Scan point decoder channels
// Byte input channel and point result channel, valid/ready.
// ---------------------------------------------------------------------------
interface lspd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface lspd_point_if;
  logic              valid;
  logic              ready;
  logic signed [14:0] angle_centideg;
  logic [15:0]       distance;
  logic [4:0]        intensity;
  logic [7:0]        point_index;
  logic [7:0]        kept_number;
  modport source (output valid, output angle_centideg, output distance,
                  output intensity, output point_index, output kept_number,
                  input ready);
  modport sink (input valid, input angle_centideg, input distance,
                input intensity, input point_index, input kept_number,
                output ready);
endinterface

// File: rtl/core/lidar_scan_point_decoder_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Lidar scan point decoder
// Frame parsing of received bytes and two-arctangent point compensation.
// ---------------------------------------------------------------------------
//  channel  dir  beat
//  in_ch    in   one received byte
//  out_ch   out  one compensated kept point
//  cfg_*    in   register write, no handshake
//
//  Header, skip, low bytes and dropped points are accepted in S_IDLE, which they do not leave.
//  A kept point runs three passes of the 64-step divider, four passes of the
//  20-step CORDIC, a reciprocal angle scaling (estimate, then compare and
//  correct) and the single-state setup steps CALC, SUM, MUL_A and MUL_B.
//  in_ch.ready is low while a point is computed; a finished point waits in
//  the output register and only a second kept point stalls on out_ch.ready.
//  rst_n is synchronous; reset clears control/config registers and the header hunt.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module lidar_scan_point_decoder_top import lspd_pkg::*; #(
  parameter int RAW_POINTS_PER_FRAME = 160,
  parameter int MAX_POINTS           = 160
) (
  input  logic                  clk,
  input  logic                  rst_n,
  lspd_byte_if.sink             in_ch,
  lspd_point_if.source          out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);
  lspd_cmd_t cmd;
  lspd_sts_t sts;

  lspd_ctrl #(
    .RAW_POINTS_PER_FRAME (RAW_POINTS_PER_FRAME),
    .MAX_POINTS           (MAX_POINTS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .sts       (sts),
    .cmd       (cmd)
  );

  lspd_datapath u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_idx        (cfg_idx),
    .cfg_wdata      (cfg_wdata),
    .rx_byte        (in_ch.rx_byte),
    .cmd            (cmd),
    .sts            (sts),
    .angle_centideg (out_ch.angle_centideg),
    .distance       (out_ch.distance),
    .intensity      (out_ch.intensity),
    .point_index    (out_ch.point_index),
    .kept_number    (out_ch.kept_number)
  );

  `LSPD_ASSERT_IMP(a_ready_no_kick, clk, rst_n, in_ch.ready, !cmd.start)
  `LSPD_ASSERT_NXT(a_kick_pulse, clk, rst_n, cmd.start, !cmd.start)
  `LSPD_ASSERT_IMP(a_units_apart, clk, rst_n, 1'b1, $onehot0({sts.div_done, sts.cor_done}))
  `LSPD_ASSERT_IMP(a_div_owner, clk, rst_n, sts.div_done, cmd.op == OP_DIV_P || cmd.op == OP_DIV_Q || cmd.op == OP_DIV_DST || cmd.op == OP_DIV_ANG)
  `LSPD_ASSERT_IMP(a_out_kept, clk, rst_n, out_ch.valid, out_ch.intensity >= MIN_INTEN && out_ch.kept_number != 8'd0)
endmodule

// File: rtl/core/lspd_div.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Iterative unsigned divider
// Restoring division, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module lspd_div import lspd_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             done,
  output logic [DVD_W-1:0] quotient
);
  localparam int CNT_W = $clog2(DVD_W);

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [DVD_W-1:0] dvd_r;
  logic [DVS_W:0]   rem_r;
  logic [DVS_W-1:0] dvs_r;
  logic [DVS_W:0]   rem_sh;
  logic             ge;

  always_comb begin
    rem_sh = {rem_r[DVS_W-1:0], dvd_r[DVD_W-1]};
    ge     = rem_sh >= {1'b0, dvs_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(DVD_W - 1);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      dvs_r <= divisor;
      rem_r <= '0;
    end else if (busy_r) begin
      rem_r <= ge ? (rem_sh - {1'b0, dvs_r}) : rem_sh;
      dvd_r <= {dvd_r[DVD_W-2:0], ge};
    end
  end

  assign done     = done_r;
  assign quotient = dvd_r;
endmodule

// File: rtl/core/lspd_cordic.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Iterative CORDIC
// Shared vectoring (atan) and rotation (cos) unit, one step per cycle.
// ---------------------------------------------------------------------------
module lspd_cordic import lspd_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic                 vec,
  input  logic signed [CW-1:0] x0,
  input  logic signed [CW-1:0] y0,
  input  logic signed [ZW-1:0] z0,
  output logic                 done,
  output logic signed [CW-1:0] x_out,
  output logic signed [ZW-1:0] z_out
);
  logic                 busy_r;
  logic                 done_r;
  logic                 vec_r;
  logic [KW-1:0]        k_r;
  logic signed [CW-1:0] x_r;
  logic signed [CW-1:0] y_r;
  logic signed [ZW-1:0] z_r;
  logic signed [CW-1:0] xs;
  logic signed [CW-1:0] ys;
  logic signed [ZW-1:0] ang;
  logic                 up;

  always_comb begin
    xs  = x_r >>> k_r;
    ys  = y_r >>> k_r;
    ang = step_angle(k_r);
    up  = vec_r ? ~y_r[CW-1] : z_r[ZW-1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      k_r    <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        k_r    <= '0;
      end else if (busy_r) begin
        k_r <= k_r + 1'b1;
        if (k_r == KW'(STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      vec_r <= vec;
      x_r   <= x0;
      y_r   <= y0;
      z_r   <= z0;
    end else if (busy_r) begin
      if (up) begin
        x_r <= x_r + ys;
        y_r <= y_r - xs;
        z_r <= z_r + ang;
      end else begin
        x_r <= x_r - ys;
        y_r <= y_r + xs;
        z_r <= z_r - ang;
      end
    end
  end

  assign done  = done_r;
  assign x_out = x_r;
  assign z_out = z_r;
endmodule

// File: rtl/core/lspd_datapath.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Scan point decoder datapath
// Registers, word assembly, compensation arithmetic and result register.
// ---------------------------------------------------------------------------
module lspd_datapath import lspd_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic [7:0]            rx_byte,
  input  lspd_cmd_t             cmd,
  output lspd_sts_t             sts,
  output logic signed [14:0]    angle_centideg,
  output logic [15:0]           distance,
  output logic [4:0]            intensity,
  output logic [7:0]            point_index,
  output logic [7:0]            kept_number
);
  localparam int DW   = 30;
  localparam int NW   = 62;
  localparam int CSW  = 20;
  localparam int P1W  = 32;
  localparam int DENW = 38;
  localparam int AW   = ZW + ANG_MUL_W;
  localparam int ANG_RW = ANG_XW + ANG_RCP_W;

  logic [15:0] slope_near_r, offset_near_r, slope_far_r, offset_far_r;
  logic [7:0]  bias_r;
  logic [7:0]  low_r;

  logic [10:0]             dist_r;
  logic [4:0]              inten_r;
  logic [7:0]              idx_r, kept_r;
  logic signed [12:0]      t_r;
  logic signed [DW-1:0]    d0_r, d1_r;
  logic signed [31:0]      ratio_r;
  logic signed [ZW-1:0]    p_r, q_r, qa_r;
  logic                    a_neg_r;
  logic [ZW-1:0]           abs_a_r;
  logic [AW-1:0]           angprod_r;
  logic signed [CSW-1:0]   cosa_r, cosq_r;
  logic signed [P1W-1:0]   prod1_r;
  logic signed [DENW-1:0]  den_r;
  logic signed [NW-1:0]    num_r;
  logic [15:0]             dout_r;
  logic signed [14:0]      cd_r;
  logic                    ang_step_r;
  logic [ANG_QW-1:0]       ang_est_r;
  logic                    ang_big_r;

  logic signed [14:0] out_ang_r;
  logic [15:0]        out_dist_r;
  logic [4:0]         out_inten_r;
  logic [7:0]         out_idx_r, out_kept_r;

  logic [15:0]          word;
  logic [11:0]          idx10;
  logic signed [12:0]   t_nxt;
  logic signed [DW-1:0] k0, b0, k1, b1, tx, d0_nxt, d1_nxt;
  logic signed [DW-1:0] d_sel, n_sel;
  logic [DW-1:0]        abs_n, abs_d;
  logic [30:0]          sm;
  logic signed [31:0]   ratio_nxt;
  logic signed [ZW:0]   sum_pq;
  logic signed [ZW-1:0] a_nxt;
  logic [ZW-1:0]        abs_a;
  logic signed [P1W-1:0] prod1_nxt;
  logic signed [DENW-1:0] den_nxt;
  logic signed [NW-1:0] num_nxt;
  logic [15:0]          dout_nxt;
  logic [ANG_RW-1:0]    ang_rprod;
  logic [ANG_QW-1:0]    ang_est_nxt;
  logic [AW-1:0]        ang_back;
  logic [AW-1:0]        ang_rem;
  logic [ANG_QW-1:0]    ang_q;
  logic [13:0]          cd_mag;
  logic signed [14:0]   cd_nxt;

  logic                 div_start, div_done;
  logic [DVD_W-1:0]     dvd, quot;
  logic [DVS_W-1:0]     dvs;
  logic                 cor_start, cor_done, vec;
  logic signed [CW-1:0] x0, y0, x_out;
  logic signed [ZW-1:0] z0, z_out;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slope_near_r  <= '0;
      offset_near_r <= '0;
      slope_far_r   <= '0;
      offset_far_r  <= '0;
      bias_r        <= '0;
      low_r         <= '0;
      ang_step_r    <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (reg_idx_t'(cfg_idx))
          REG_SLOPE_NEAR:  slope_near_r  <= cfg_wdata;
          REG_OFFSET_NEAR: offset_near_r <= cfg_wdata;
          REG_SLOPE_FAR:   slope_far_r   <= cfg_wdata;
          REG_OFFSET_FAR:  offset_far_r  <= cfg_wdata;
          REG_INDEX_BIAS:  bias_r        <= cfg_wdata[7:0];
          default: ;
        endcase
      end
      if (cmd.op == OP_HOLD) low_r <= rx_byte;
      ang_step_r <= cmd.start && (cmd.op == OP_DIV_ANG);
    end
  end

  always_comb begin
    word = {rx_byte, low_r};
    sts.hdr_hit  = rx_byte == HDR_BYTE;
    sts.pt_ok    = (word[10:0] != '0) && (word[15:11] >= MIN_INTEN);
    sts.div_done = div_done || ang_step_r;
    sts.cor_done = cor_done;

    idx10 = {4'b0, cmd.idx} * 12'd10;
    t_nxt = $signed({1'b0, idx10}) - $signed({{5{bias_r[7]}}, bias_r});

    k0 = {{(DW-16){slope_near_r[15]}}, slope_near_r};
    b0 = {{(DW-16){offset_near_r[15]}}, offset_near_r};
    k1 = {{(DW-16){slope_far_r[15]}}, slope_far_r};
    b1 = {{(DW-16){offset_far_r[15]}}, offset_far_r};
    tx = {{(DW-13){t_r[12]}}, t_r};
    d0_nxt = k0 * DW'(10) + b0 * tx;
    d1_nxt = k1 * DW'(10) + b1 * tx;

    d_sel = (cmd.op == OP_DIV_Q) ? d1_r : d0_r;
    n_sel = DW'(SCALE_1E5) - d_sel;
    abs_n = n_sel[DW-1] ? DW'(-n_sel) : DW'(n_sel);
    abs_d = d_sel[DW-1] ? DW'(-d_sel) : DW'(d_sel);

    sm = (|quot[DVD_W-1:31]) ? RATIO_MAX : quot[30:0];
    if (d_sel == '0) begin
      if (n_sel[DW-1])      ratio_nxt = -$signed({1'b0, RATIO_MAX});
      else if (n_sel != '0) ratio_nxt = $signed({1'b0, RATIO_MAX});
      else                  ratio_nxt = '0;
    end else if (n_sel[DW-1] ^ d_sel[DW-1]) begin
      ratio_nxt = -$signed({1'b0, sm});
    end else begin
      ratio_nxt = $signed({1'b0, sm});
    end

    sum_pq = {p_r[ZW-1], p_r} + {q_r[ZW-1], q_r};
    a_nxt  = sum_pq[ZW:1];
    abs_a  = a_nxt[ZW-1] ? ZW'(-a_nxt) : ZW'(a_nxt);

    prod1_nxt = $signed({{(P1W-11){1'b0}}, dist_r}) *
                $signed({{(P1W-CSW){cosa_r[CSW-1]}}, cosa_r});
    den_nxt   = $signed({{(DENW-CSW){cosq_r[CSW-1]}}, cosq_r}) * DENW'(SCALE_1E5);
    num_nxt   = $signed({{(NW-P1W){prod1_r[P1W-1]}}, prod1_r}) *
                $signed({{(NW-DW){d1_r[DW-1]}}, d1_r});

    if (num_r[NW-1] || num_r == '0)          dout_nxt = '0;
    else if (den_r[DENW-1] || den_r == '0)   dout_nxt = 16'hFFFF;
    else if (|quot[DVD_W-1:16])              dout_nxt = 16'hFFFF;
    else                                     dout_nxt = quot[15:0];

    ang_rprod   = {{ANG_RCP_W{1'b0}}, abs_a_r[ANG_XW-1:0]} * ANG_RW'(ANG_RCP);
    ang_est_nxt = ang_rprod[ANG_SH +: ANG_QW];
    ang_back    = {{(AW-ANG_QW){1'b0}}, ang_est_r} * AW'(ANG_DIV);
    ang_rem     = angprod_r - ang_back;
    ang_q       = ang_est_r + {{(ANG_QW-1){1'b0}}, (ang_rem >= AW'(ANG_DIV))};

    cd_mag = (ang_big_r || ang_q > ANG_QW'(ANG_MAX)) ? 14'(ANG_MAX) : ang_q;
    cd_nxt = a_neg_r ? -$signed({1'b0, cd_mag}) : $signed({1'b0, cd_mag});

    dvd = '0;
    dvs = '0;
    case (cmd.op)
      OP_DIV_P, OP_DIV_Q: begin
        dvd = {{(DVD_W-DW-16){1'b0}}, abs_n, 16'b0};
        dvs = {{(DVS_W-DW){1'b0}}, abs_d};
      end
      OP_DIV_DST: begin
        dvd = {{(DVD_W-NW){1'b0}}, num_r};
        dvs = den_r[DVS_W-1:0];
      end
      default: ;
    endcase
    div_start = cmd.start && (cmd.op == OP_DIV_P || cmd.op == OP_DIV_Q ||
                              cmd.op == OP_DIV_DST);

    vec       = (cmd.op == OP_ATN_P) || (cmd.op == OP_ATN_Q);
    x0        = vec ? CW'(Q_ONE) : CW'(CORDIC_X0);
    y0        = vec ? {{(CW-32){ratio_r[31]}}, ratio_r} : '0;
    z0        = (cmd.op == OP_COS_A) ? qa_r : ((cmd.op == OP_COS_Q) ? q_r : '0);
    cor_start = cmd.start && (vec || cmd.op == OP_COS_A || cmd.op == OP_COS_Q);
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_CAPTURE: begin
        dist_r  <= word[10:0];
        inten_r <= word[15:11];
        idx_r   <= cmd.idx;
        kept_r  <= cmd.kept;
        t_r     <= t_nxt;
      end
      OP_CALC: begin
        d0_r <= d0_nxt;
        d1_r <= d1_nxt;
      end
      OP_DIV_P, OP_DIV_Q: if (div_done) ratio_r <= ratio_nxt;
      OP_ATN_P: if (cor_done) p_r <= z_out;
      OP_ATN_Q: if (cor_done) q_r <= z_out;
      OP_SUM: begin
        qa_r      <= q_r - a_nxt;
        a_neg_r   <= a_nxt[ZW-1];
        abs_a_r   <= abs_a;
        angprod_r <= {{ANG_MUL_W{1'b0}}, abs_a} * AW'(ANG_MUL);
      end
      OP_COS_A: if (cor_done) cosa_r <= x_out[CSW-1:0];
      OP_COS_Q: if (cor_done) cosq_r <= x_out[CSW-1:0];
      OP_MUL_A: begin
        prod1_r <= prod1_nxt;
        den_r   <= den_nxt;
      end
      OP_MUL_B: num_r <= num_nxt;
      OP_DIV_DST: if (div_done) dout_r <= dout_nxt;
      OP_DIV_ANG: begin
        if (cmd.start) begin
          ang_est_r <= ang_est_nxt;
          ang_big_r <= |abs_a_r[ZW-1:ANG_XW];
        end
        if (ang_step_r) cd_r <= cd_nxt;
      end
      OP_EMIT: begin
        out_ang_r   <= cd_r;
        out_dist_r  <= dout_r;
        out_inten_r <= inten_r;
        out_idx_r   <= idx_r;
        out_kept_r  <= kept_r;
      end
      default: ;
    endcase
  end

  lspd_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (dvd),
    .divisor  (dvs),
    .done     (div_done),
    .quotient (quot)
  );

  lspd_cordic u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cor_start),
    .vec   (vec),
    .x0    (x0),
    .y0    (y0),
    .z0    (z0),
    .done  (cor_done),
    .x_out (x_out),
    .z_out (z_out)
  );

  assign angle_centideg = out_ang_r;
  assign distance       = out_dist_r;
  assign intensity      = out_inten_r;
  assign point_index    = out_idx_r;
  assign kept_number    = out_kept_r;
endmodule

// File: rtl/core/lspd_ctrl.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Scan point decoder controller
// Header hunt, frame byte tracking and compensation sequencing.
// ---------------------------------------------------------------------------
module lspd_ctrl import lspd_pkg::*; #(
  parameter int RAW_POINTS_PER_FRAME = 160,
  parameter int MAX_POINTS           = 160
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  logic      out_ready,
  output logic      out_valid,
  input  lspd_sts_t sts,
  output lspd_cmd_t cmd
);
  localparam int POS_W = $clog2(SKIP_BYTES + 2 * RAW_POINTS_PER_FRAME + 1);

  typedef enum logic [13:0] {
    S_IDLE     = 14'b00000000000001,
    S_CALC     = 14'b00000000000010,
    S_DIV_P    = 14'b00000000000100,
    S_ATN_P    = 14'b00000000001000,
    S_DIV_Q    = 14'b00000000010000,
    S_ATN_Q    = 14'b00000000100000,
    S_SUM      = 14'b00000001000000,
    S_COS_A    = 14'b00000010000000,
    S_COS_Q    = 14'b00000100000000,
    S_MUL_A    = 14'b00001000000000,
    S_MUL_B    = 14'b00010000000000,
    S_DIV_DST  = 14'b00100000000000,
    S_DIV_ANG  = 14'b01000000000000,
    S_EMIT     = 14'b10000000000000
  } state_t;

  state_t           state_r, state_nxt;
  logic             kick_r, kick_nxt;
  logic [1:0]       run_r;
  logic             in_frame_r;
  logic [POS_W-1:0] pos_r;
  logic [7:0]       kept_r;
  logic             out_valid_r;

  logic             accept, in_data, hold, capture, last, load_out;
  logic [POS_W-1:0] off;
  logic [7:0]       idx;

  always_comb begin
    in_ready = state_r == S_IDLE;
    accept   = in_valid && in_ready;
    off      = pos_r - POS_W'(SKIP_BYTES);
    idx      = 8'(off >> 1);
    in_data  = accept && in_frame_r && (pos_r >= POS_W'(SKIP_BYTES));
    hold     = in_data && !off[0];
    last     = idx >= 8'(RAW_POINTS_PER_FRAME - 1);
    capture  = in_data && off[0] && sts.pt_ok && (kept_r < 8'(MAX_POINTS));
    load_out = (state_r == S_EMIT) && (!out_valid_r || out_ready);

    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:    if (capture) state_nxt = S_CALC;
      S_CALC:    state_nxt = S_DIV_P;
      S_DIV_P:   if (sts.div_done) state_nxt = S_ATN_P;
      S_ATN_P:   if (sts.cor_done) state_nxt = S_DIV_Q;
      S_DIV_Q:   if (sts.div_done) state_nxt = S_ATN_Q;
      S_ATN_Q:   if (sts.cor_done) state_nxt = S_SUM;
      S_SUM:     state_nxt = S_COS_A;
      S_COS_A:   if (sts.cor_done) state_nxt = S_COS_Q;
      S_COS_Q:   if (sts.cor_done) state_nxt = S_MUL_A;
      S_MUL_A:   state_nxt = S_MUL_B;
      S_MUL_B:   state_nxt = S_DIV_DST;
      S_DIV_DST: if (sts.div_done) state_nxt = S_DIV_ANG;
      S_DIV_ANG: if (sts.div_done) state_nxt = S_EMIT;
      S_EMIT:    if (load_out) state_nxt = S_IDLE;
      default:   state_nxt = S_IDLE;
    endcase

    kick_nxt = (state_nxt != state_r) &&
               (state_nxt == S_DIV_P || state_nxt == S_ATN_P || state_nxt == S_DIV_Q ||
                state_nxt == S_ATN_Q || state_nxt == S_COS_A || state_nxt == S_COS_Q ||
                state_nxt == S_DIV_DST || state_nxt == S_DIV_ANG);

    unique case (state_r)
      S_IDLE:    cmd.op = capture ? OP_CAPTURE : (hold ? OP_HOLD : OP_NONE);
      S_CALC:    cmd.op = OP_CALC;
      S_DIV_P:   cmd.op = OP_DIV_P;
      S_ATN_P:   cmd.op = OP_ATN_P;
      S_DIV_Q:   cmd.op = OP_DIV_Q;
      S_ATN_Q:   cmd.op = OP_ATN_Q;
      S_SUM:     cmd.op = OP_SUM;
      S_COS_A:   cmd.op = OP_COS_A;
      S_COS_Q:   cmd.op = OP_COS_Q;
      S_MUL_A:   cmd.op = OP_MUL_A;
      S_MUL_B:   cmd.op = OP_MUL_B;
      S_DIV_DST: cmd.op = OP_DIV_DST;
      S_DIV_ANG: cmd.op = OP_DIV_ANG;
      S_EMIT:    cmd.op = load_out ? OP_EMIT : OP_NONE;
      default:   cmd.op = OP_NONE;
    endcase
    cmd.start = kick_r;
    cmd.idx   = idx;
    cmd.kept  = kept_r + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      kick_r      <= 1'b0;
      run_r       <= '0;
      in_frame_r  <= 1'b0;
      pos_r       <= '0;
      kept_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      kick_r  <= kick_nxt;
      if (load_out)       out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
      if (capture) kept_r <= kept_r + 1'b1;
      if (accept) begin
        if (!in_frame_r) begin
          if (sts.hdr_hit) begin
            if (run_r == 2'd3) begin
              run_r      <= '0;
              in_frame_r <= 1'b1;
              pos_r      <= '0;
              kept_r     <= '0;
            end else begin
              run_r <= run_r + 1'b1;
            end
          end else begin
            run_r <= '0;
          end
        end else if (in_data && off[0] && last) begin
          in_frame_r <= 1'b0;
          run_r      <= '0;
          pos_r      <= '0;
        end else begin
          pos_r <= pos_r + 1'b1;
        end
      end
    end
  end

  assign out_valid = out_valid_r;
endmodule
